[src/svf_pkg.sv]
package svf_pkg;

  // Default write data store depth per bank
  localparam int unsigned StoreDepthDef = 64;

  // Saturation point of the byte counters
  localparam logic [6:0] CountMax = 7'd127;

  // Frame byte positions
  localparam logic [6:0] PosOp   = 7'd4;
  localparam logic [6:0] PosFunc = 7'd5;
  localparam logic [6:0] PosLen  = 7'd6;
  localparam logic [6:0] PosData = 7'd7;

  // Bytes around the write data: 7 header bytes plus 2 checksum bytes
  localparam logic [6:0] ReadMinLen = 7'd9;
  localparam logic [9:0] FrameOverhead = 10'd9;

  // Entries in the job queue between front and back
  localparam int unsigned QueueDepth = 2;

  // Configuration register indexes
  typedef enum logic [2:0] {
    CfgHeadByte  = 3'd0,
    CfgTypeByte  = 3'd1,
    CfgReadCode  = 3'd2,
    CfgWriteCode = 3'd3,
    CfgMinLen    = 3'd4,
    CfgMaxLen    = 3'd5
  } cfg_idx_e;

  typedef struct packed {
    logic [7:0] head_byte;
    logic [7:0] type_byte;
    logic [7:0] read_code;
    logic [7:0] write_code;
    logic [6:0] min_len;
    logic [6:0] max_len;
  } cfg_t;

  // One judged chunk, handed from the front to the back
  typedef struct packed {
    logic       err;
    logic       is_read;
    logic [7:0] func;
    logic [7:0] len;
    logic       bank;
  } job_t;

endpackage

[src/svf_front.sv]
module svf_front
  import svf_pkg::*;
#(
  parameter int unsigned STORE_DEPTH = StoreDepthDef,
  localparam int unsigned IdxW = $clog2(STORE_DEPTH)
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  cfg_t            cfg_i,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  logic [7:0]      rx_byte_i,
  input  logic            chunk_end_i,
  input  logic            q_full_i,
  output logic            push_o,
  output job_t            job_o,
  output logic            mem_we_o,
  output logic            mem_bank_o,
  output logic [IdxW-1:0] mem_addr_o,
  output logic [7:0]      mem_data_o
);

  localparam logic [9:0] StoreDepthW = 10'(STORE_DEPTH);

  logic [6:0]  cc_q, cc_d;
  logic [7:0]  prev_q, prev_d;
  logic        hs_q, hs_d;
  logic [6:0]  fp_q, fp_d;
  logic [7:0]  op_q, op_d;
  logic [7:0]  func_q, func_d;
  logic [7:0]  len_q, len_d;
  logic [15:0] sum_q, sum_d;
  logic [15:0] chk_q, chk_d;
  logic        bank_q;

  logic        accept;
  logic        rd;
  logic [8:0]  sum_end;
  logic [8:0]  pos9;
  logic [9:0]  data_off;
  logic        store_we;
  logic        err;
  logic [9:0]  len_need;

  assign in_ready_o = !q_full_i;
  assign accept     = in_valid_i && in_ready_o;

  // Advance the per-chunk state by one byte
  always_comb begin
    cc_d     = (cc_q < CountMax) ? cc_q + 7'd1 : cc_q;
    prev_d   = prev_q;
    hs_d     = hs_q;
    fp_d     = fp_q;
    op_d     = op_q;
    func_d   = func_q;
    len_d    = len_q;
    sum_d    = sum_q;
    chk_d    = chk_q;
    store_we = 1'b0;
    rd       = 1'b0;
    sum_end  = 9'd0;
    pos9     = {2'b00, fp_q};
    data_off = 10'(fp_q) - 10'(PosData);
    if (!hs_q) begin
      if ((cc_q != 7'd0) && (prev_q == cfg_i.head_byte) && (rx_byte_i == cfg_i.type_byte)) begin
        hs_d  = 1'b1;
        fp_d  = 7'd2;
        sum_d = 16'(prev_q) + 16'(rx_byte_i);
      end
      prev_d = rx_byte_i;
    end else if (fp_q < CountMax) begin
      fp_d = fp_q + 7'd1;
      if (fp_q == PosOp)   op_d   = rx_byte_i;
      if (fp_q == PosFunc) func_d = rx_byte_i;
      if (fp_q == PosLen)  len_d  = rx_byte_i;
      rd      = (op_d == cfg_i.read_code);
      sum_end = rd ? 9'(PosData) : ({1'b0, len_d} + 9'(PosData));
      if (pos9 < sum_end) begin
        sum_d    = sum_q + 16'(rx_byte_i);
        store_we = !rd && (fp_q >= PosData) && (data_off < StoreDepthW);
      end else if (pos9 == sum_end) begin
        chk_d = {rx_byte_i, 8'h00};
      end else if (pos9 == sum_end + 9'd1) begin
        chk_d = {chk_q[15:8], rx_byte_i};
      end
    end
  end

  // Judge the chunk from the state after its final byte
  always_comb begin
    len_need = 10'(len_d) + FrameOverhead;
    err      = 1'b0;
    if ((cc_d < cfg_i.min_len) || (cc_d > cfg_i.max_len)) begin
      err = 1'b1;
    end else if (!hs_d) begin
      err = 1'b1;
    end else if ((fp_d < cfg_i.min_len) || (fp_d > cfg_i.max_len)) begin
      err = 1'b1;
    end else if (fp_d < PosData) begin
      err = 1'b1;
    end else if (op_d == cfg_i.read_code) begin
      err = (fp_d < ReadMinLen) || (sum_d != chk_d);
    end else if (op_d == cfg_i.write_code) begin
      err = (len_need > 10'(fp_d)) || (len_need > StoreDepthW) || (sum_d != chk_d);
    end else begin
      err = 1'b1;
    end
  end

  assign push_o        = accept && chunk_end_i;
  assign job_o.err     = err;
  assign job_o.is_read = (op_d == cfg_i.read_code);
  assign job_o.func    = func_d;
  assign job_o.len     = len_d;
  assign job_o.bank    = bank_q;

  assign mem_we_o   = accept && store_we;
  assign mem_bank_o = bank_q;
  assign mem_addr_o = data_off[IdxW-1:0];
  assign mem_data_o = rx_byte_i;

  // Hold state between bytes, clear it at chunk end
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cc_q   <= '0;
      prev_q <= '0;
      hs_q   <= 1'b0;
      fp_q   <= '0;
      op_q   <= '0;
      func_q <= '0;
      len_q  <= '0;
      sum_q  <= '0;
      chk_q  <= '0;
      bank_q <= 1'b0;
    end else if (accept) begin
      if (chunk_end_i) begin
        cc_q   <= '0;
        prev_q <= '0;
        hs_q   <= 1'b0;
        fp_q   <= '0;
        op_q   <= '0;
        func_q <= '0;
        len_q  <= '0;
        sum_q  <= '0;
        chk_q  <= '0;
        bank_q <= !bank_q;
      end else begin
        cc_q   <= cc_d;
        prev_q <= prev_d;
        hs_q   <= hs_d;
        fp_q   <= fp_d;
        op_q   <= op_d;
        func_q <= func_d;
        len_q  <= len_d;
        sum_q  <= sum_d;
        chk_q  <= chk_d;
      end
    end
  end

endmodule

[src/svf_queue.sv]
module svf_queue
  import svf_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  job_t job_i,
  input  logic pop_i,
  output logic valid_o,
  output logic full_o,
  output job_t head_o
);

  localparam int unsigned PtrW = $clog2(QueueDepth);

  job_t            slot_q [QueueDepth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [PtrW:0]   count_q;

  assign valid_o = (count_q != '0);
  assign full_o  = (count_q == (PtrW + 1)'(QueueDepth));
  assign head_o  = slot_q[rd_ptr_q];

  // Store pushed jobs
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= job_i;
    end
  end

  // Advance pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(QueueDepth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(QueueDepth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + (PtrW + 1)'(1);
      end else if (pop_i && !push_i) begin
        count_q <= count_q - (PtrW + 1)'(1);
      end
    end
  end

endmodule

[src/svf_back.sv]
module svf_back
  import svf_pkg::*;
#(
  parameter int unsigned STORE_DEPTH = StoreDepthDef,
  localparam int unsigned IdxW = $clog2(STORE_DEPTH)
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            job_valid_i,
  input  job_t            job_i,
  output logic            pop_o,
  input  logic            mem_we_i,
  input  logic            mem_bank_i,
  input  logic [IdxW-1:0] mem_addr_i,
  input  logic [7:0]      mem_data_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output logic            frame_status_o,
  output logic            is_write_o,
  output logic [7:0]      function_code_o,
  output logic [7:0]      length_byte_o,
  output logic            has_payload_o,
  output logic [7:0]      payload_byte_o,
  output logic [5:0]      payload_index_o,
  output logic            last_result_o
);

  logic [7:0] mem0 [STORE_DEPTH];
  logic [7:0] mem1 [STORE_DEPTH];

  logic       out_valid_q;
  logic       status_q, is_write_q, has_pay_q, last_q, sel_q;
  logic [7:0] func_q, len_q, rd0_q, rd1_q;
  logic [5:0] pidx_q;
  logic [7:0] idx_q;

  logic advance, issue, is_pay, last;

  assign advance = !out_valid_q || out_ready_i;
  assign issue   = advance && job_valid_i;
  assign is_pay  = !job_i.err && !job_i.is_read && (job_i.len != 8'd0);
  assign last    = !is_pay || ((idx_q + 8'd1) == job_i.len);
  assign pop_o   = issue && last;

  // Write data banks; reads are registered at each issued result
  always_ff @(posedge clk_i) begin
    if (mem_we_i) begin
      if (mem_bank_i) begin
        mem1[mem_addr_i] <= mem_data_i;
      end else begin
        mem0[mem_addr_i] <= mem_data_i;
      end
    end
    if (issue) begin
      rd0_q <= mem0[idx_q[IdxW-1:0]];
      rd1_q <= mem1[idx_q[IdxW-1:0]];
    end
  end

  // Load the result register
  always_ff @(posedge clk_i) begin
    if (issue) begin
      status_q   <= job_i.err;
      is_write_q <= !job_i.err && !job_i.is_read;
      func_q     <= job_i.err ? 8'd0 : job_i.func;
      len_q      <= job_i.err ? 8'd0 : job_i.len;
      has_pay_q  <= is_pay;
      pidx_q     <= is_pay ? idx_q[5:0] : 6'd0;
      last_q     <= last;
      sel_q      <= job_i.bank;
    end
  end

  // Track result valid and the payload counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      idx_q       <= '0;
    end else begin
      if (advance) begin
        out_valid_q <= job_valid_i;
      end
      if (issue && is_pay) begin
        idx_q <= last ? 8'd0 : idx_q + 8'd1;
      end
    end
  end

  assign out_valid_o     = out_valid_q;
  assign frame_status_o  = status_q;
  assign is_write_o      = is_write_q;
  assign function_code_o = func_q;
  assign length_byte_o   = len_q;
  assign has_payload_o   = has_pay_q;
  assign payload_byte_o  = has_pay_q ? (sel_q ? rd1_q : rd0_q) : 8'd0;
  assign payload_index_o = pidx_q;
  assign last_result_o   = last_q;

endmodule

[src/sensor_frame_validator_top.sv]
// Sensor frame validator. Takes one chunk byte per cycle on the input
// request channel, with chunk_end_i on the final byte, and checks the master
// frame inside it (header and type bytes, operation, length bounds, 16-bit
// additive checksum). At the chunk end it returns one error result, one read
// or empty-write summary, or one result per write data byte, one result per
// cycle while the output is taken. Bytes are taken back to back at one per
// cycle; judged chunks wait in a two-entry job queue, and the input stalls
// only while both entries are held, since each queued write uses one of two
// data banks of STORE_DEPTH bytes. Configuration writes are taken at any edge
// with cfg_we_i high and should be made while the block is idle.
module sensor_frame_validator_top
  import svf_pkg::*;
#(
  parameter int unsigned STORE_DEPTH = StoreDepthDef
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [2:0] cfg_idx_i,
  input  logic [7:0] cfg_wdata_i,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] rx_byte_i,
  input  logic       chunk_end_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic       frame_status_o,
  output logic       is_write_o,
  output logic [7:0] function_code_o,
  output logic [7:0] length_byte_o,
  output logic       has_payload_o,
  output logic [7:0] payload_byte_o,
  output logic [5:0] payload_index_o,
  output logic       last_result_o
);

  localparam int unsigned IdxW = $clog2(STORE_DEPTH);

  cfg_t            cfg_q;
  logic            q_full, q_valid, push, pop;
  job_t            job_in, job_head;
  logic            mem_we, mem_bank;
  logic [IdxW-1:0] mem_addr;
  logic [7:0]      mem_data;

  // Decode configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.head_byte  <= 8'd0;
      cfg_q.type_byte  <= 8'd0;
      cfg_q.read_code  <= 8'd0;
      cfg_q.write_code <= 8'd1;
      cfg_q.min_len    <= 7'd9;
      cfg_q.max_len    <= 7'd64;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgHeadByte:  cfg_q.head_byte  <= cfg_wdata_i;
        CfgTypeByte:  cfg_q.type_byte  <= cfg_wdata_i;
        CfgReadCode:  cfg_q.read_code  <= cfg_wdata_i;
        CfgWriteCode: cfg_q.write_code <= cfg_wdata_i;
        CfgMinLen:    cfg_q.min_len    <= cfg_wdata_i[6:0];
        CfgMaxLen:    cfg_q.max_len    <= cfg_wdata_i[6:0];
        default: ;
      endcase
    end
  end

  svf_front #(
    .STORE_DEPTH(STORE_DEPTH)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .rx_byte_i  (rx_byte_i),
    .chunk_end_i(chunk_end_i),
    .q_full_i   (q_full),
    .push_o     (push),
    .job_o      (job_in),
    .mem_we_o   (mem_we),
    .mem_bank_o (mem_bank),
    .mem_addr_o (mem_addr),
    .mem_data_o (mem_data)
  );

  svf_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .job_i  (job_in),
    .pop_i  (pop),
    .valid_o(q_valid),
    .full_o (q_full),
    .head_o (job_head)
  );

  svf_back #(
    .STORE_DEPTH(STORE_DEPTH)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .job_valid_i    (q_valid),
    .job_i          (job_head),
    .pop_o          (pop),
    .mem_we_i       (mem_we),
    .mem_bank_i     (mem_bank),
    .mem_addr_i     (mem_addr),
    .mem_data_i     (mem_data),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .frame_status_o (frame_status_o),
    .is_write_o     (is_write_o),
    .function_code_o(function_code_o),
    .length_byte_o  (length_byte_o),
    .has_payload_o  (has_payload_o),
    .payload_byte_o (payload_byte_o),
    .payload_index_o(payload_index_o),
    .last_result_o  (last_result_o)
  );

endmodule
